// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Stable priority ready queue package
// Command codes and the control bundle shared by the queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CMD_BITS = 2;
	localparam int ID_BITS  = 8;
	localparam int IN_PRIO_BITS = 8;

	localparam logic [CMD_BITS-1:0] CMD_INSERT  = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_APPEND  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_DEQUEUE = 2'd2;
	localparam logic [CMD_BITS-1:0] CMD_NOP     = 2'd3;

	// Control broadcast to every cell in the chain.
	typedef struct packed {
		logic load;       // an insert or append that is taken this cycle while the queue is not full
		logic prio_mode;  // the load is a priority insert, not an append
		logic pop;        // a dequeue that is taken this cycle
	} spq_ctrl_t;

endpackage

// ===== rtl/core/stable_priority_ready_queue.sv =====
// ----------------------------------------------------------------------------
// Stable priority ready queue
// Bounded queue of process entries kept in service order in a chain of cells.
// ----------------------------------------------------------------------------
// Throughput: one item per clock cycle while the master side takes each result;
// the whole chain updates in the cycle the item is accepted, set by the
// insertion-point search that ripples once along the row of cells.
// Output: the result for an item is on the master side in the cycle after it
// is accepted. Reset empties the queue at once; slot contents are not reset.
// ----------------------------------------------------------------------------
module stable_priority_ready_queue #(
	parameter int DEPTH     = 16,
	parameter int PRIO_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input items.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] proc_id, [15:8] proc_priority
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	// Result items.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_id, [15:8] out_priority
	output logic [3:0]  m_tuser    // [0] out_valid, [1] is_empty, [2] is_full,
	                               // [3] dropped
);

	localparam int IDW = spq_pkg::ID_BITS;
	localparam int IPW = spq_pkg::IN_PRIO_BITS;
	// Number of priority bits that pass between the stream fields and the cells.
	localparam int NPW = (PRIO_BITS < IPW) ? PRIO_BITS : IPW;

	// Per-cell view of the chain. found[i] is high when the insertion point
	// lies in a cell before cell i, so cell i takes its left neighbor.
	logic                 cell_valid [DEPTH];
	logic [IDW-1:0]       cell_id    [DEPTH];
	logic [PRIO_BITS-1:0] cell_prio  [DEPTH];
	logic [DEPTH:0]       found;

	spq_pkg::spq_ctrl_t   ctrl;
	logic                 accept;
	logic                 full_now;
	logic                 is_ins;
	logic                 is_deq;
	logic [IDW-1:0]       new_id;
	logic [PRIO_BITS-1:0] new_prio;

	// Output register.
	logic                 m_valid_q;
	logic [IDW-1:0]       out_id_q;
	logic [IPW-1:0]       out_prio_q;
	logic                 out_valid_q;
	logic                 is_empty_q;
	logic                 is_full_q;
	logic                 dropped_q;

	// A new item may enter whenever the output register is free or is being
	// emptied in the same cycle.
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// The queue is full exactly when the last cell holds an entry.
	assign full_now = cell_valid[DEPTH-1];
	assign is_ins   = (s_tuser == spq_pkg::CMD_INSERT) || (s_tuser == spq_pkg::CMD_APPEND);
	assign is_deq   = (s_tuser == spq_pkg::CMD_DEQUEUE);

	assign ctrl.load      = accept && is_ins && !full_now;
	assign ctrl.prio_mode = (s_tuser == spq_pkg::CMD_INSERT);
	assign ctrl.pop       = accept && is_deq;

	assign new_id = s_tdata[IDW-1:0];

	// The stored priority keeps the low PRIO_BITS bits of the input field,
	// with zeros above bit seven when PRIO_BITS is wider than the field.
	assign new_prio = PRIO_BITS'(s_tdata[IDW +: NPW]);

	assign found[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                 lv;
		logic [IDW-1:0]       lid;
		logic [PRIO_BITS-1:0] lprio;
		logic                 rv;
		logic [IDW-1:0]       rid;
		logic [PRIO_BITS-1:0] rprio;

		// The head never shifts from the left; the tail refills with a free
		// slot on a dequeue.
		if (i == 0) begin : g_head
			assign lv    = 1'b0;
			assign lid   = new_id;
			assign lprio = new_prio;
		end else begin : g_mid_l
			assign lv    = cell_valid[i-1];
			assign lid   = cell_id[i-1];
			assign lprio = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign rv    = 1'b0;
			assign rid   = new_id;
			assign rprio = new_prio;
		end else begin : g_mid_r
			assign rv    = cell_valid[i+1];
			assign rid   = cell_id[i+1];
			assign rprio = cell_prio[i+1];
		end

		spq_cell #(
			.PRIO_BITS (PRIO_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_id      (new_id),
			.new_prio    (new_prio),
			.left_valid  (lv),
			.left_id     (lid),
			.left_prio   (lprio),
			.right_valid (rv),
			.right_id    (rid),
			.right_prio  (rprio),
			.found_in    (found[i]),
			.found_out   (found[i+1]),
			.valid       (cell_valid[i]),
			.id          (cell_id[i]),
			.prio        (cell_prio[i])
		);
	end

	// Handshake state of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Result fields. The flags describe the queue after this item: the
	// occupancy is a thermometer over the cell valid bits, so the state after
	// a load or a pop is read from the neighbor of the end cell.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_valid_q <= ctrl.pop && cell_valid[0];
			dropped_q   <= is_ins && full_now;
			if (ctrl.pop && cell_valid[0]) begin
				out_id_q   <= cell_id[0];
				out_prio_q <= IPW'(cell_prio[0][NPW-1:0]);
			end else begin
				out_id_q   <= '0;
				out_prio_q <= '0;
			end
			if (ctrl.load) begin
				is_empty_q <= 1'b0;
				is_full_q  <= cell_valid[DEPTH-2];
			end else if (ctrl.pop) begin
				is_empty_q <= !cell_valid[1];
				is_full_q  <= 1'b0;
			end else begin
				is_empty_q <= !cell_valid[0];
				is_full_q  <= full_now;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {out_prio_q, out_id_q};
	assign m_tuser  = {dropped_q, is_full_q, is_empty_q, out_valid_q};

endmodule

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Stable priority ready queue cell
// One queue slot: holds an entry, finds whether a new entry lands here, and
// shifts toward the tail on a load or toward the head on a pop.
// ----------------------------------------------------------------------------
module spq_cell #(
	parameter int PRIO_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spq_pkg::spq_ctrl_t          ctrl,
	input  logic [spq_pkg::ID_BITS-1:0] new_id,
	input  logic [PRIO_BITS-1:0]        new_prio,
	input  logic                        left_valid,
	input  logic [spq_pkg::ID_BITS-1:0] left_id,
	input  logic [PRIO_BITS-1:0]        left_prio,
	input  logic                        right_valid,
	input  logic [spq_pkg::ID_BITS-1:0] right_id,
	input  logic [PRIO_BITS-1:0]        right_prio,
	input  logic                        found_in,
	output logic                        found_out,
	output logic                        valid,
	output logic [spq_pkg::ID_BITS-1:0] id,
	output logic [PRIO_BITS-1:0]        prio
);

	logic                        valid_q;
	logic [spq_pkg::ID_BITS-1:0] id_q;
	logic [PRIO_BITS-1:0]        prio_q;
	logic                        here;

	// The new entry belongs in the first slot that is free or, for a
	// priority insert, holds a strictly lower priority.
	assign here      = !valid_q || (ctrl.prio_mode && (prio_q < new_prio));
	assign found_out = found_in || here;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= right_valid;
		end else if (ctrl.load) begin
			if (found_in) begin
				valid_q <= left_valid;
			end else if (here) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			id_q   <= right_id;
			prio_q <= right_prio;
		end else if (ctrl.load) begin
			if (found_in) begin
				id_q   <= left_id;
				prio_q <= left_prio;
			end else if (here) begin
				id_q   <= new_id;
				prio_q <= new_prio;
			end
		end
	end

	assign valid = valid_q;
	assign id    = id_q;
	assign prio  = prio_q;

endmodule
